@@ rtl/pfh_pkg.sv @@
`timescale 1ns / 1ps

package pfh_pkg;

  // fixed formats
  localparam int ANGLE_W      = 16;
  localparam int SCAN_SAMPLES = 360;
  localparam int CORDIC_STEPS = 20;
  localparam int CNT_W        = 11;
  localparam int DIV_W        = 56;
  localparam int DIV_STEPS_W  = 6;
  localparam int CW           = 36;
  localparam int ZW           = 34;
  localparam int NORM_BITS    = 20;

  // field gains, Q16.16 scaled; KINV is the inverse cordic gain scaled by 2^30
  localparam logic [34:0]          ATT_GAIN   = 35'd34178263780;
  localparam logic [31:0]          REP_GAIN   = 32'd341782638;
  localparam logic signed [CW-1:0] KINV       = 36'sd652032874;
  localparam logic signed [39:0]   NO_REPEL_X = 40'sd7;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_GOAL_X     = 3'd0,
    CFG_GOAL_Y     = 3'd1,
    CFG_SCAN_START = 3'd2,
    CFG_SCAN_STEP  = 3'd3,
    CFG_TURN_TOL   = 3'd4,
    CFG_RANGE_LOW  = 3'd5,
    CFG_RANGE_HIGH = 3'd6
  } pfh_cfg_t;

  // motion command codes
  typedef enum logic [1:0] {
    MOT_FWD   = 2'd0,
    MOT_LEFT  = 2'd1,
    MOT_RIGHT = 2'd2
  } pfh_motion_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ABS,
    OP_ATT_ZERO,
    OP_NORM,
    OP_SQX,
    OP_SQY,
    OP_DEN,
    OP_NUMX,
    OP_DIVX,
    OP_STORE_AX,
    OP_NUMY,
    OP_DIVY,
    OP_STORE_AY,
    OP_PREP,
    OP_SMP_START,
    OP_MULX,
    OP_ACCX,
    OP_ACCY,
    OP_FIN_SUM,
    OP_VEC_START,
    OP_TARGET,
    OP_EMIT
  } pfh_op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic at_goal;
    logic norm_more;
    logic smp_ok;
    logic last;
    logic div_busy;
    logic cor_busy;
    logic fin_zero;
    logic out_stall;
  } pfh_stat_t;

  // arctangent of 2^-i as a fraction of a full turn, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/pfh_div.sv @@
`timescale 1ns / 1ps

module pfh_div import pfh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DIV_W-1:0]       num,
  input  logic [DIV_W-1:0]       den,
  input  logic [DIV_STEPS_W-1:0] steps,
  output logic                   busy,
  output logic [DIV_W-1:0]       quo
);

  logic                   busy_r;
  logic [DIV_STEPS_W-1:0] cnt_r;
  logic [DIV_W-1:0]       rem_r;
  logic [DIV_W-1:0]       num_r;
  logic [DIV_W-1:0]       den_r;
  logic [DIV_W-1:0]       quo_r;
  logic [DIV_W:0]         trial;
  logic [DIV_W:0]         diff;
  logic                   ge;

  // one restoring step: bring down the next numerator bit
  assign trial = {rem_r, num_r[DIV_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_STEPS_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      num_r <= {num_r[DIV_W-2:0], 1'b0};
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

@@ rtl/pfh_cordic.sv @@
`timescale 1ns / 1ps

module pfh_cordic import pfh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 vec_mode,
  input  logic signed [CW-1:0] x0,
  input  logic signed [CW-1:0] y0,
  input  logic signed [ZW-1:0] z0,
  output logic                 busy,
  output logic signed [CW-1:0] x,
  output logic signed [CW-1:0] y,
  output logic signed [ZW-1:0] z
);

  logic                 busy_r;
  logic                 mode_r;
  logic [4:0]           step_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] da;
  logic                 pos;

  // rotation steers z to zero, vectoring steers y to zero
  assign dx  = y_r >>> step_r;
  assign dy  = x_r >>> step_r;
  assign da  = $signed({2'b00, atan_turn(step_r)});
  assign pos = mode_r ? y_r[CW-1] : !z_r[ZW-1];

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == 5'(CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  // micro-rotations
  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= vec_mode;
      x_r    <= x0;
      y_r    <= y0;
      z_r    <= z0;
    end else if (busy_r) begin
      if (pos) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - da;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + da;
      end
    end
  end

  assign busy = busy_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;

endmodule

@@ rtl/pfh_datapath.sv @@
`timescale 1ns / 1ps

module pfh_datapath import pfh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_kind,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic [15:0]        in_heading,
  input  logic [15:0]        in_range,
  input  logic [9:0]         in_sample_index,
  input  logic               in_last,
  input  pfh_op_t            op,
  output pfh_stat_t          st,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_motion,
  output logic signed [31:0] out_final_x,
  output logic signed [31:0] out_final_y,
  output logic signed [15:0] out_heading_error
);

  // configuration
  logic signed [31:0] goal_x_r, goal_y_r;
  logic [15:0]        scan_start_r, scan_step_r;
  logic [14:0]        turn_tol_r;
  logic [15:0]        range_low_r, range_high_r;

  // pose, field and scan state
  logic signed [31:0]  robot_x_r, robot_y_r;
  logic [ANGLE_W-1:0]  robot_heading_r;
  logic signed [31:0]  attract_x_r, attract_y_r;
  logic signed [39:0]  acc_x_r, acc_y_r;
  logic [CNT_W-1:0]    valid_count_r;
  logic                out_valid_r, out_valid_nxt;

  // working registers
  logic [15:0]        range_r;
  logic [9:0]         idx_r;
  logic               last_r;
  logic [32:0]        ux_r, uy_r;
  logic               negx_r, negy_r;
  logic [3:0]         sh_r;
  logic [DIV_W-1:0]   prod_r, den_r;
  logic [15:0]        phi_r;
  logic               flip_r;
  logic signed [62:0] mres_r;
  logic signed [31:0] fx_r, fy_r;
  logic               base_r;
  logic [15:0]        err_r;
  logic [1:0]         mot_r;
  logic [1:0]         out_motion_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic [15:0]        out_err_r;

  // combinational
  logic signed [32:0]   dxw, dyw;
  logic [32:0]          m_abs;
  logic [39:0]          sq_a, sq_b;
  logic [DIV_W-1:0]     den_sum;
  logic [19:0]          gm_op;
  logic [54:0]          gm;
  logic [31:0]          rr;
  logic [15:0]          step_mul;
  logic [15:0]          phi_sum;
  logic [31:0]          rep_num;
  logic                 div_start, div_busy;
  logic [DIV_W-1:0]     div_num, div_den, div_quo;
  logic [DIV_STEPS_W-1:0] div_steps;
  logic [30:0]          att_mag;
  logic signed [31:0]   att_val;
  logic                 cor_start, cor_vec, cor_busy;
  logic signed [CW-1:0] cor_x0, cor_y0, cor_x, cor_y;
  logic signed [ZW-1:0] cor_z0, cor_z;
  logic [31:0]          ang32;
  logic                 ang_flip;
  logic signed [CW-1:0] cos_full, sin_full;
  logic signed [31:0]   mul_c;
  logic signed [30:0]   q_s;
  logic signed [62:0]   mul_p;
  logic signed [62:0]   rnd;
  logic signed [39:0]   rep_step;
  logic signed [39:0]   rx, ry;
  logic signed [40:0]   sum_x, sum_y;
  logic signed [CW-1:0] fx_ext, fy_ext;
  logic [31:0]          tsum;
  logic [ANGLE_W-1:0]   target;
  logic [15:0]          err_w;
  logic signed [16:0]   err_s, tol_s;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > 41'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -41'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // goal offset magnitudes
  assign dxw   = {goal_x_r[31], goal_x_r} - {robot_x_r[31], robot_x_r};
  assign dyw   = {goal_y_r[31], goal_y_r} - {robot_y_r[31], robot_y_r};
  assign m_abs = (ux_r > uy_r) ? ux_r : uy_r;

  // squares and gain products
  assign sq_a    = {20'd0, ux_r[19:0]} * {20'd0, ux_r[19:0]};
  assign sq_b    = {20'd0, uy_r[19:0]} * {20'd0, uy_r[19:0]};
  assign den_sum = den_r + prod_r;
  assign gm_op   = (op == OP_NUMY) ? uy_r[19:0] : ux_r[19:0];
  assign gm      = {20'd0, ATT_GAIN} * {35'd0, gm_op};

  // sample range, angle and force numerator
  assign rr       = {16'd0, range_r} * {16'd0, range_r};
  assign step_mul = scan_step_r * {6'd0, idx_r};
  assign phi_sum  = scan_start_r + robot_heading_r + step_mul;
  assign rep_num  = REP_GAIN + prod_r[32:1];

  // divider launch
  always_comb begin
    div_start = 1'b0;
    div_num   = prod_r + {1'b0, den_r[DIV_W-1:1]};
    div_den   = den_r;
    div_steps = DIV_STEPS_W'(DIV_W);
    case (op)
      OP_DIVX, OP_DIVY: begin
        div_start = 1'b1;
      end
      OP_SMP_START: begin
        div_start = 1'b1;
        div_num   = {rep_num, 24'd0};
        div_den   = prod_r;
        div_steps = DIV_STEPS_W'(32);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pfh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // attraction component, saturated with sign restored
  assign att_mag = (|div_quo[DIV_W-1:31]) ? 31'h7fff_ffff : div_quo[30:0];
  always_comb begin
    if ((op == OP_STORE_AY) ? negy_r : negx_r) begin
      att_val = -$signed({1'b0, att_mag});
    end else begin
      att_val = $signed({1'b0, att_mag});
    end
  end

  // sample angle folded into the right half plane
  assign ang32    = {phi_r, 16'd0};
  assign ang_flip = ang32[31] ^ ang32[30];
  assign fx_ext   = {{(CW-32){fx_r[31]}}, fx_r};
  assign fy_ext   = {{(CW-32){fy_r[31]}}, fy_r};

  // cordic launch
  always_comb begin
    cor_start = 1'b0;
    cor_vec   = 1'b0;
    cor_x0    = KINV;
    cor_y0    = '0;
    cor_z0    = {{(ZW-32){ang32[31] ^ ang_flip}}, ang32[31] ^ ang_flip, ang32[30:0]};
    case (op)
      OP_SMP_START: begin
        cor_start = 1'b1;
      end
      OP_VEC_START: begin
        cor_start = 1'b1;
        cor_vec   = 1'b1;
        cor_x0    = fx_r[31] ? -fx_ext : fx_ext;
        cor_y0    = fx_r[31] ? -fy_ext : fy_ext;
        cor_z0    = '0;
      end
      default: begin
        cor_start = 1'b0;
      end
    endcase
  end

  pfh_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cor_start),
    .vec_mode (cor_vec),
    .x0       (cor_x0),
    .y0       (cor_y0),
    .z0       (cor_z0),
    .busy     (cor_busy),
    .x        (cor_x),
    .y        (cor_y),
    .z        (cor_z)
  );

  // force times cosine or sine
  assign cos_full = flip_r ? -cor_x : cor_x;
  assign sin_full = flip_r ? -cor_y : cor_y;
  assign mul_c    = (op == OP_MULX) ? cos_full[31:0] : sin_full[31:0];
  assign q_s      = $signed({1'b0, div_quo[29:0]});
  assign mul_p    = 63'(q_s) * 63'(mul_c);
  assign rnd      = mres_r + 63'sd536870912;
  assign rep_step = {{7{rnd[62]}}, rnd[62:30]};

  // summed field
  assign rx    = (valid_count_r != '0) ? acc_x_r : NO_REPEL_X;
  assign ry    = (valid_count_r != '0) ? acc_y_r : 40'sd0;
  assign sum_x = {{9{attract_x_r[31]}}, attract_x_r} + {rx[39], rx};
  assign sum_y = {{9{attract_y_r[31]}}, attract_y_r} + {ry[39], ry};

  // heading of the sum and wrapped error
  assign tsum   = {base_r, 31'd0} + cor_z[31:0] + (32'd1 << (31 - ANGLE_W));
  assign target = tsum[31 -: ANGLE_W];
  assign err_w  = target - robot_heading_r;
  assign err_s  = {err_w[15], err_w};
  assign tol_s  = {2'b00, turn_tol_r};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r      <= '0;
      goal_y_r      <= '0;
      scan_start_r  <= '0;
      scan_step_r   <= 16'd182;
      turn_tol_r    <= 15'd2086;
      range_low_r   <= 16'd26;
      range_high_r  <= 16'd25600;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GOAL_X:     goal_x_r     <= cfg_data;
        CFG_GOAL_Y:     goal_y_r     <= cfg_data;
        CFG_SCAN_START: scan_start_r <= cfg_data[15:0];
        CFG_SCAN_STEP:  scan_step_r  <= cfg_data[15:0];
        CFG_TURN_TOL:   turn_tol_r   <= cfg_data[14:0];
        CFG_RANGE_LOW:  range_low_r  <= cfg_data[15:0];
        CFG_RANGE_HIGH: range_high_r <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // result slot
  always_comb begin
    if (op == OP_EMIT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // pose, attraction and repulsion state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      robot_x_r       <= '0;
      robot_y_r       <= '0;
      robot_heading_r <= '0;
      attract_x_r     <= '0;
      attract_y_r     <= '0;
      acc_x_r         <= '0;
      acc_y_r         <= '0;
      valid_count_r   <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (op)
        OP_LOAD: begin
          if (!in_kind) begin
            robot_x_r       <= in_pos_x;
            robot_y_r       <= in_pos_y;
            robot_heading_r <= in_heading[ANGLE_W-1:0];
          end
        end
        OP_ATT_ZERO: begin
          attract_x_r <= '0;
          attract_y_r <= '0;
        end
        OP_STORE_AX: attract_x_r <= att_val;
        OP_STORE_AY: attract_y_r <= att_val;
        OP_ACCX:     acc_x_r <= acc_x_r - rep_step;
        OP_ACCY: begin
          acc_y_r <= acc_y_r - rep_step;
          if (valid_count_r != '1) begin
            valid_count_r <= valid_count_r + 1'b1;
          end
        end
        OP_EMIT: begin
          acc_x_r       <= '0;
          acc_y_r       <= '0;
          valid_count_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        range_r <= in_range;
        idx_r   <= in_sample_index;
        last_r  <= in_last;
      end
      OP_ABS: begin
        negx_r <= dxw[32];
        negy_r <= dyw[32];
        ux_r   <= dxw[32] ? 33'(-dxw) : 33'(dxw);
        uy_r   <= dyw[32] ? 33'(-dyw) : 33'(dyw);
        sh_r   <= '0;
      end
      OP_NORM: begin
        ux_r <= ux_r >> 1;
        uy_r <= uy_r >> 1;
        sh_r <= sh_r + 1'b1;
      end
      OP_SQX: prod_r <= {16'd0, sq_a};
      OP_SQY: begin
        den_r  <= prod_r;
        prod_r <= {16'd0, sq_b};
      end
      OP_DEN:  den_r  <= den_sum << sh_r;
      OP_NUMX, OP_NUMY: prod_r <= {1'b0, gm};
      OP_PREP: begin
        prod_r <= {24'd0, rr};
        phi_r  <= phi_sum;
      end
      OP_SMP_START: flip_r <= ang_flip;
      OP_MULX:      mres_r <= mul_p;
      OP_ACCX:      mres_r <= mul_p;
      OP_FIN_SUM: begin
        fx_r  <= sat32(sum_x);
        fy_r  <= sat32(sum_y);
        err_r <= '0;
        mot_r <= MOT_FWD;
      end
      OP_VEC_START: base_r <= fx_r[31];
      OP_TARGET: begin
        err_r <= err_w;
        if (err_s > tol_s) begin
          mot_r <= MOT_LEFT;
        end else if (err_s < -tol_s) begin
          mot_r <= MOT_RIGHT;
        end else begin
          mot_r <= MOT_FWD;
        end
      end
      OP_EMIT: begin
        out_motion_r <= mot_r;
        out_x_r      <= fx_r;
        out_y_r      <= fy_r;
        out_err_r    <= err_r;
      end
      default: begin
      end
    endcase
  end

  // status
  assign st.at_goal   = (m_abs == '0);
  assign st.norm_more = |m_abs[32:NORM_BITS];
  assign st.smp_ok    = (range_r > range_low_r) && (range_r < range_high_r) &&
                        ({1'b0, idx_r} < 11'(SCAN_SAMPLES));
  assign st.last      = last_r;
  assign st.div_busy  = div_busy;
  assign st.cor_busy  = cor_busy;
  assign st.fin_zero  = (fx_r == '0) && (fy_r == '0);
  assign st.out_stall = out_valid_r && !out_ready;

  assign out_valid         = out_valid_r;
  assign out_motion        = out_motion_r;
  assign out_final_x       = out_x_r;
  assign out_final_y       = out_y_r;
  assign out_heading_error = out_err_r;

endmodule

@@ rtl/pfh_ctrl.sv @@
`timescale 1ns / 1ps

module pfh_ctrl import pfh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  output logic      in_ready,
  input  pfh_stat_t st,
  output pfh_op_t   op
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_ABS,
    S_NORM,
    S_SQY,
    S_DEN,
    S_NUMX,
    S_DIVX,
    S_WAITX,
    S_NUMY,
    S_DIVY,
    S_WAITY,
    S_PREP,
    S_START,
    S_SWAIT,
    S_ACCX,
    S_ACCY,
    S_FIN,
    S_FCHK,
    S_VWAIT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // sequencing
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = in_kind ? S_PREP : S_ABS;
        end
      end
      S_ABS: begin
        op        = OP_ABS;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (st.at_goal) begin
          op        = OP_ATT_ZERO;
          state_nxt = S_IDLE;
        end else if (st.norm_more) begin
          op = OP_NORM;
        end else begin
          op        = OP_SQX;
          state_nxt = S_SQY;
        end
      end
      S_SQY: begin
        op        = OP_SQY;
        state_nxt = S_DEN;
      end
      S_DEN: begin
        op        = OP_DEN;
        state_nxt = S_NUMX;
      end
      S_NUMX: begin
        op        = OP_NUMX;
        state_nxt = S_DIVX;
      end
      S_DIVX: begin
        op        = OP_DIVX;
        state_nxt = S_WAITX;
      end
      S_WAITX: begin
        if (!st.div_busy) begin
          op        = OP_STORE_AX;
          state_nxt = S_NUMY;
        end
      end
      S_NUMY: begin
        op        = OP_NUMY;
        state_nxt = S_DIVY;
      end
      S_DIVY: begin
        op        = OP_DIVY;
        state_nxt = S_WAITY;
      end
      S_WAITY: begin
        if (!st.div_busy) begin
          op        = OP_STORE_AY;
          state_nxt = S_IDLE;
        end
      end
      S_PREP: begin
        op = OP_PREP;
        if (st.smp_ok) begin
          state_nxt = S_START;
        end else begin
          state_nxt = st.last ? S_FIN : S_IDLE;
        end
      end
      S_START: begin
        op        = OP_SMP_START;
        state_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        if (!st.div_busy && !st.cor_busy) begin
          op        = OP_MULX;
          state_nxt = S_ACCX;
        end
      end
      S_ACCX: begin
        op        = OP_ACCX;
        state_nxt = S_ACCY;
      end
      S_ACCY: begin
        op        = OP_ACCY;
        state_nxt = st.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        op        = OP_FIN_SUM;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (st.fin_zero) begin
          state_nxt = S_EMIT;
        end else begin
          op        = OP_VEC_START;
          state_nxt = S_VWAIT;
        end
      end
      S_VWAIT: begin
        if (!st.cor_busy) begin
          op        = OP_TARGET;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!st.out_stall) begin
          op        = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

`ifndef NO_ASSERTIONS
  // a result is only loaded into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT) |-> !st.out_stall)
    else $error("result loaded over a pending beat");

  // the divider is never restarted while it is still iterating
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_DIVX || op == OP_DIVY || op == OP_SMP_START) |-> !st.div_busy)
    else $error("divider restarted while busy");

  // the shared cordic is never restarted while it is still iterating
  a_cor_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_SMP_START || op == OP_VEC_START) |-> !st.cor_busy)
    else $error("cordic restarted while busy");

  // one item at a time: no second beat right after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");
`endif

endmodule

@@ rtl/potential_field_heading_controller.sv @@
`timescale 1ns / 1ps

// Potential-field heading controller. Odometry beats (in_kind 0) store the
// pose and compute the goal attraction; lidar beats (in_kind 1) add one
// repulsion term per valid sample, and the beat flagged in_last ends the
// scan and yields exactly one out beat with the motion command, the summed
// field vector and the signed heading error. One item is in work at a time.
// A valid sample uses the 32-step shared divider, with the 20-step cordic
// sine/cosine running alongside. An odometry beat zeroes the attraction
// when the robot sits at the goal; else it takes up to 13 normalizing
// shifts and two 56-step divisions for the attraction components. The
// scan-ending beat adds the cordic heading (skipped when the summed vector
// is zero), plus any wait for the result slot. Configuration writes take
// effect at once and must be made while the block is idle.
module potential_field_heading_controller import pfh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic [15:0]        in_heading,
  input  logic [15:0]        in_range,
  input  logic [9:0]         in_sample_index,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_motion,
  output logic signed [31:0] out_final_x,
  output logic signed [31:0] out_final_y,
  output logic signed [15:0] out_heading_error
);

  pfh_op_t   op;
  pfh_stat_t st;

  pfh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .st       (st),
    .op       (op)
  );

  pfh_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_kind           (in_kind),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_heading        (in_heading),
    .in_range          (in_range),
    .in_sample_index   (in_sample_index),
    .in_last           (in_last),
    .op                (op),
    .st                (st),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motion        (out_motion),
    .out_final_x       (out_final_x),
    .out_final_y       (out_final_y),
    .out_heading_error (out_heading_error)
  );

endmodule
